// ===== hw/rtl/tepq_pkg.sv =====
`default_nettype none

package tepq_pkg;

	localparam int DEFAULT_QUEUE_DEPTH = 32;

	localparam int TIME_W   = 64;
	localparam int KIND_W   = 16;
	localparam int HANDLE_W = 32;
	localparam int STATUS_W = 3;
	localparam int PEND_W   = 6;
	localparam int ENTRY_W  = TIME_W + KIND_W + HANDLE_W;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 64;

	localparam logic REG_STOP_TIME = 1'b0;

	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_POPPED   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_CONTINUE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_STOPPED  = 3'd4;

endpackage

`default_nettype wire

// ===== hw/rtl/timed_event_priority_queue.sv =====
// Channel   Direction  Handshake            Payload
// in        sink       in_valid/in_ready    opcode, event_time, event_kind, event_handle,
//                                           target_time
// out       source     out_valid/out_ready  status, out_time, out_kind, out_handle,
//                                           now_time, pending, inserted_total, last
// apb       slave      psel/penable/pready  paddr, pwrite, pwdata, prdata (stop_time at 0)
//
// An insert scans back from the tail, moving each stored event later than it up one slot
// until it reaches an event not later than it or the head; each step of the backward scan is
// one read and one compare on the event store's port.
// An advance gives a result for each popped event and ends with a closing result.
// A new transfer is taken only when the previous item has produced all its results.
// Reset empties the queue, arms the stop event and sets stop_time to all ones.
// A stalled output holds the sequencer; no result is dropped.
`default_nettype none

module timed_event_priority_queue #(
	parameter int QUEUE_DEPTH = tepq_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,

	input  wire logic                             in_valid,
	output      logic                             in_ready,
	input  wire logic                             opcode,
	input  wire logic [tepq_pkg::TIME_W-1:0]      event_time,
	input  wire logic [tepq_pkg::KIND_W-1:0]      event_kind,
	input  wire logic [tepq_pkg::HANDLE_W-1:0]    event_handle,
	input  wire logic [tepq_pkg::TIME_W-1:0]      target_time,

	output      logic                             out_valid,
	input  wire logic                             out_ready,
	output      logic [tepq_pkg::STATUS_W-1:0]    status,
	output      logic [tepq_pkg::TIME_W-1:0]      out_time,
	output      logic [tepq_pkg::KIND_W-1:0]      out_kind,
	output      logic [tepq_pkg::HANDLE_W-1:0]    out_handle,
	output      logic [tepq_pkg::TIME_W-1:0]      now_time,
	output      logic [tepq_pkg::PEND_W-1:0]      pending,
	output      logic [tepq_pkg::HANDLE_W-1:0]    inserted_total,
	output      logic                             last,

	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [tepq_pkg::PADDR_W-1:0]     paddr,
	input  wire logic [tepq_pkg::PDATA_W-1:0]     pwdata,
	output      logic [tepq_pkg::PDATA_W-1:0]     prdata,
	output      logic                             pready
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = AW + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [AW-1:0] LAST_A  = AW'(QUEUE_DEPTH - 1);
	localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_INS_RD   = 7'b0000010,
		S_INS_CMP  = 7'b0000100,
		S_ADV_RD   = 7'b0001000,
		S_ADV_STOP = 7'b0010000,
		S_ADV_TGT  = 7'b0100000,
		S_EMIT     = 7'b1000000
	} state_t;

	state_t state_q;

	logic [tepq_pkg::TIME_W-1:0]   time_q;
	logic [tepq_pkg::KIND_W-1:0]   kind_q;
	logic [tepq_pkg::HANDLE_W-1:0] handle_q;
	logic [tepq_pkg::TIME_W-1:0]   target_q;
	logic [tepq_pkg::TIME_W-1:0]   stop_q;
	logic [tepq_pkg::TIME_W-1:0]   now_q;
	logic [tepq_pkg::TIME_W-1:0]   t_q;
	logic [tepq_pkg::HANDLE_W-1:0] ins_q;
	logic [AW-1:0]                 head_q;
	logic [AW-1:0]                 pos_q;
	logic [CW-1:0]                 cnt_q;
	logic [CW-1:0]                 k_q;
	logic                          armed_q;
	logic                          use_stop_q;

	logic [tepq_pkg::STATUS_W-1:0] res_status_q;
	logic [tepq_pkg::TIME_W-1:0]   res_time_q;
	logic [tepq_pkg::KIND_W-1:0]   res_kind_q;
	logic [tepq_pkg::HANDLE_W-1:0] res_handle_q;
	logic                          res_last_q;

	logic                          out_valid_q;
	logic [tepq_pkg::STATUS_W-1:0] status_q;
	logic [tepq_pkg::TIME_W-1:0]   out_time_q;
	logic [tepq_pkg::KIND_W-1:0]   out_kind_q;
	logic [tepq_pkg::HANDLE_W-1:0] out_handle_q;
	logic [tepq_pkg::TIME_W-1:0]   now_time_q;
	logic [tepq_pkg::PEND_W-1:0]   pending_q;
	logic [tepq_pkg::HANDLE_W-1:0] inserted_total_q;
	logic                          last_q;

	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [tepq_pkg::ENTRY_W-1:0]  ram_wdata;
	logic                          ram_re;
	logic [AW-1:0]                 ram_raddr;
	logic [tepq_pkg::ENTRY_W-1:0]  ram_rdata;

	logic [tepq_pkg::TIME_W-1:0]   rd_time;
	logic [tepq_pkg::KIND_W-1:0]   rd_kind;
	logic [tepq_pkg::HANDLE_W-1:0] rd_handle;
	logic [tepq_pkg::ENTRY_W-1:0]  new_entry;

	logic [tepq_pkg::TIME_W-1:0]   cmp_a;
	logic [tepq_pkg::TIME_W-1:0]   cmp_b;
	logic                          cmp_le;

	logic [SW-1:0]                 tail_sum;
	logic [AW-1:0]                 tail;
	logic [AW-1:0]                 pos_dec;
	logic [AW-1:0]                 head_inc;
	logic                          cfg_wr;
	logic                          emit_free;
	logic                          emit_fire;

	assign rd_time   = ram_rdata[tepq_pkg::ENTRY_W-1 -: tepq_pkg::TIME_W];
	assign rd_kind   = ram_rdata[tepq_pkg::HANDLE_W +: tepq_pkg::KIND_W];
	assign rd_handle = ram_rdata[tepq_pkg::HANDLE_W-1:0];
	assign new_entry = {time_q, kind_q, handle_q};

	assign tail_sum = SW'(head_q) + SW'(cnt_q);
	assign tail     = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
	assign pos_dec  = (pos_q == '0) ? LAST_A : pos_q - AW'(1);
	assign head_inc = (head_q == LAST_A) ? '0 : head_q + AW'(1);

	assign cfg_wr    = psel && penable && pwrite && pready
		&& (paddr[tepq_pkg::PADDR_W-1] == tepq_pkg::REG_STOP_TIME);
	assign emit_free = !out_valid_q || out_ready;
	assign emit_fire = (state_q == S_EMIT) && emit_free;

	// The one time comparator of the block, shared by the insert scan and the advance steps.
	always_comb begin
		unique case (state_q)
			S_INS_CMP: begin
				cmp_a = rd_time;
				cmp_b = time_q;
			end
			S_ADV_STOP: begin
				cmp_a = stop_q;
				cmp_b = rd_time;
			end
			default: begin
				cmp_a = t_q;
				cmp_b = target_q;
			end
		endcase
	end

	assign cmp_le = (cmp_a <= cmp_b);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = new_entry;
		ram_re    = 1'b0;
		ram_raddr = pos_dec;
		unique case (state_q)
			S_INS_RD: begin
				if (k_q == '0) begin
					ram_we = 1'b1;
				end else begin
					ram_re = 1'b1;
				end
			end
			S_INS_CMP: begin
				ram_we    = 1'b1;
				ram_wdata = cmp_le ? new_entry : ram_rdata;
			end
			S_ADV_RD: begin
				ram_re    = (cnt_q != '0);
				ram_raddr = head_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	tepq_ram #(
		.WIDTH (tepq_pkg::ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			stop_q      <= '1;
			now_q       <= '0;
			ins_q       <= '0;
			head_q      <= '0;
			cnt_q       <= '0;
			armed_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				stop_q <= pwdata;
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						time_q   <= event_time;
						kind_q   <= event_kind;
						handle_q <= event_handle;
						target_q <= target_time;
						if (opcode == tepq_pkg::OP_ADVANCE) begin
							state_q <= S_ADV_RD;
						end else if (cnt_q == DEPTH_C) begin
							res_status_q <= tepq_pkg::ST_FULL;
							res_time_q   <= event_time;
							res_kind_q   <= event_kind;
							res_handle_q <= event_handle;
							res_last_q   <= 1'b1;
							state_q      <= S_EMIT;
						end else begin
							pos_q   <= tail;
							k_q     <= cnt_q;
							state_q <= S_INS_RD;
						end
					end
				end
				S_INS_RD: begin
					if (k_q == '0) begin
						cnt_q        <= cnt_q + CW'(1);
						ins_q        <= ins_q + tepq_pkg::HANDLE_W'(1);
						res_status_q <= tepq_pkg::ST_INSERTED;
						res_time_q   <= time_q;
						res_kind_q   <= kind_q;
						res_handle_q <= handle_q;
						res_last_q   <= 1'b1;
						state_q      <= S_EMIT;
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (cmp_le) begin
						cnt_q        <= cnt_q + CW'(1);
						ins_q        <= ins_q + tepq_pkg::HANDLE_W'(1);
						res_status_q <= tepq_pkg::ST_INSERTED;
						res_time_q   <= time_q;
						res_kind_q   <= kind_q;
						res_handle_q <= handle_q;
						res_last_q   <= 1'b1;
						state_q      <= S_EMIT;
					end else begin
						pos_q   <= pos_dec;
						k_q     <= k_q - CW'(1);
						state_q <= S_INS_RD;
					end
				end
				S_ADV_RD: begin
					if (cnt_q != '0) begin
						state_q <= S_ADV_STOP;
					end else if (armed_q) begin
						t_q        <= stop_q;
						use_stop_q <= 1'b1;
						state_q    <= S_ADV_TGT;
					end else begin
						res_status_q <= tepq_pkg::ST_CONTINUE;
						res_time_q   <= '0;
						res_kind_q   <= '0;
						res_handle_q <= '0;
						res_last_q   <= 1'b1;
						state_q      <= S_EMIT;
					end
				end
				S_ADV_STOP: begin
					use_stop_q <= armed_q && cmp_le;
					t_q        <= (armed_q && cmp_le) ? stop_q : rd_time;
					state_q    <= S_ADV_TGT;
				end
				S_ADV_TGT: begin
					now_q   <= t_q;
					state_q <= S_EMIT;
					if (!cmp_le) begin
						res_status_q <= tepq_pkg::ST_CONTINUE;
						res_time_q   <= '0;
						res_kind_q   <= '0;
						res_handle_q <= '0;
						res_last_q   <= 1'b1;
					end else if (use_stop_q) begin
						armed_q      <= 1'b0;
						res_status_q <= tepq_pkg::ST_STOPPED;
						res_time_q   <= t_q;
						res_kind_q   <= '0;
						res_handle_q <= '0;
						res_last_q   <= 1'b1;
					end else begin
						head_q       <= head_inc;
						cnt_q        <= cnt_q - CW'(1);
						res_time_q   <= t_q;
						res_kind_q   <= rd_kind;
						res_handle_q <= rd_handle;
						if (rd_kind == '0) begin
							res_status_q <= tepq_pkg::ST_STOPPED;
							res_last_q   <= 1'b1;
						end else begin
							res_status_q <= tepq_pkg::ST_POPPED;
							res_last_q   <= 1'b0;
						end
					end
				end
				S_EMIT: begin
					if (emit_free) begin
						status_q         <= res_status_q;
						out_time_q       <= res_time_q;
						out_kind_q       <= res_kind_q;
						out_handle_q     <= res_handle_q;
						now_time_q       <= now_q;
						pending_q        <= tepq_pkg::PEND_W'(cnt_q);
						inserted_total_q <= ins_q;
						last_q           <= res_last_q;
						state_q          <= res_last_q ? S_IDLE : S_ADV_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready       = (state_q == S_IDLE);
	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign out_time       = out_time_q;
	assign out_kind       = out_kind_q;
	assign out_handle     = out_handle_q;
	assign now_time       = now_time_q;
	assign pending        = pending_q;
	assign inserted_total = inserted_total_q;
	assign last           = last_q;

	assign pready = 1'b1;
	assign prdata = (paddr[tepq_pkg::PADDR_W-1] == tepq_pkg::REG_STOP_TIME) ? stop_q : '0;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH_C)
		else $error("event count exceeds the queue depth");

	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && opcode == tepq_pkg::OP_INSERT && cnt_q == DEPTH_C)
		|=> (state_q == S_EMIT && res_status_q == tepq_pkg::ST_FULL && res_last_q))
		else $error("insert into a full queue was not rejected");

	a_stop_no_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		!$rose(armed_q))
		else $error("built-in stop re-armed without reset");

	a_write_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (cnt_q < DEPTH_C))
		else $error("event store written while full");

	a_popped_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == tepq_pkg::ST_POPPED) |-> !last_q)
		else $error("popped event flagged as the final result");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/tepq_ram.sv =====
`default_nettype none

module tepq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== test/tb_timed_event_priority_queue.sv =====
`default_nettype none

module tb_timed_event_priority_queue;
	import tepq_pkg::*;

	localparam int SLOTS = DEFAULT_QUEUE_DEPTH;
	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 12;
	localparam logic [PADDR_W-1:0] STOP_ADDR = PADDR_W'(REG_STOP_TIME) << 3;
	localparam logic [PADDR_W-1:0] SPARE_ADDR = 4'd8;
	localparam logic [TIME_W-1:0] T_MAX = '1;

	typedef struct packed {
		logic                op;
		logic [TIME_W-1:0]   ev_time;
		logic [KIND_W-1:0]   ev_kind;
		logic [HANDLE_W-1:0] ev_handle;
		logic [TIME_W-1:0]   goal;
	} queue_op_t;

	typedef struct packed {
		logic [TIME_W-1:0]   at;
		logic [KIND_W-1:0]   kind;
		logic [HANDLE_W-1:0] handle;
	} sched_ev_t;

	typedef struct packed {
		logic [STATUS_W-1:0] st;
		logic [TIME_W-1:0]   at;
		logic [KIND_W-1:0]   kind;
		logic [HANDLE_W-1:0] handle;
		logic [TIME_W-1:0]   now;
		logic [PEND_W-1:0]   pend;
		logic [HANDLE_W-1:0] total;
		logic                fin;
	} queue_result_t;

	logic clk;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	queue_op_t on_bus = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [TIME_W-1:0] out_time;
	logic [KIND_W-1:0] out_kind;
	logic [HANDLE_W-1:0] out_handle;
	logic [TIME_W-1:0] now_time;
	logic [PEND_W-1:0] pending;
	logic [HANDLE_W-1:0] inserted_total;
	logic last;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	queue_op_t queued_ops[$];
	queue_result_t due_results[$];
	int unsigned ops_queued = 0;
	int unsigned ops_taken = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	bit calm = 1'b0;
	bit squeeze_req = 1'b0;
	bit squeeze_seen = 1'b0;
	int unsigned hold_left = 0;

	// Shadow of the event store and its registers.
	sched_ev_t stored[$];
	logic [TIME_W-1:0] stop_at = T_MAX;
	bit stop_live = 1'b1;
	logic [TIME_W-1:0] clock_now = '0;
	logic [HANDLE_W-1:0] ins_total = '0;

	timed_event_priority_queue #(
		.QUEUE_DEPTH(SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(on_bus.op),
		.event_time(on_bus.ev_time),
		.event_kind(on_bus.ev_kind),
		.event_handle(on_bus.ev_handle),
		.target_time(on_bus.goal),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.out_time(out_time),
		.out_kind(out_kind),
		.out_handle(out_handle),
		.now_time(now_time),
		.pending(pending),
		.inserted_total(inserted_total),
		.last(last),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		$display("MISMATCH %s: got %h want %h (cycle %0d)", what, got, want, cycle_count);
	endtask

	function automatic void note_result(input logic [STATUS_W-1:0] st,
			input logic [TIME_W-1:0] t, input logic [KIND_W-1:0] k,
			input logic [HANDLE_W-1:0] h, input logic fin);
		queue_result_t r;
		r.st = st;
		r.at = t;
		r.kind = k;
		r.handle = h;
		r.now = clock_now;
		r.pend = PEND_W'(stored.size());
		r.total = ins_total;
		r.fin = fin;
		due_results.push_back(r);
	endfunction

	function automatic void step_event_queue(input queue_op_t o);
		sched_ev_t ev;
		int p;
		bit done;
		bit use_stop;
		logic [TIME_W-1:0] t;
		if (o.op == OP_INSERT) begin
			if (stored.size() >= SLOTS) begin
				note_result(ST_FULL, o.ev_time, o.ev_kind, o.ev_handle, 1'b1);
			end else begin
				p = 0;
				while (p < stored.size() && stored[p].at <= o.ev_time)
					p++;
				ev.at = o.ev_time;
				ev.kind = o.ev_kind;
				ev.handle = o.ev_handle;
				stored.insert(p, ev);
				ins_total++;
				note_result(ST_INSERTED, o.ev_time, o.ev_kind, o.ev_handle, 1'b1);
			end
		end else begin
			done = 1'b0;
			while (!done) begin
				if (stored.size() == 0 && !stop_live) begin
					note_result(ST_CONTINUE, '0, '0, '0, 1'b1);
					done = 1'b1;
				end else begin
					use_stop = stop_live && (stored.size() == 0 || stop_at <= stored[0].at);
					t = use_stop ? stop_at : stored[0].at;
					clock_now = t;
					if (t > o.goal) begin
						note_result(ST_CONTINUE, '0, '0, '0, 1'b1);
						done = 1'b1;
					end else if (use_stop) begin
						stop_live = 1'b0;
						note_result(ST_STOPPED, t, '0, '0, 1'b1);
						done = 1'b1;
					end else begin
						ev = stored.pop_front();
						if (ev.kind == '0) begin
							note_result(ST_STOPPED, t, ev.kind, ev.handle, 1'b1);
							done = 1'b1;
						end else begin
							note_result(ST_POPPED, t, ev.kind, ev.handle, 1'b0);
						end
					end
				end
			end
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Sender: takes pending operations and presents them, idling at random unless calm is set.
	always @(posedge clk) begin : sender
		queue_op_t nxt;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				step_event_queue(on_bus);
				ops_taken++;
			end
			if (!in_valid || in_ready) begin
				if (queued_ops.size() != 0 && (calm || $urandom_range(99) >= 36)) begin
					nxt = queued_ops.pop_front();
					on_bus <= nxt;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (squeeze_req && !squeeze_seen) begin
			hold_left <= HOLD_CYCLES;
			squeeze_seen <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			out_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 36);
	end

	always @(posedge clk) begin : receiver
		queue_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				report_mismatch("result with nothing expected, status", 64'(status), '0);
			end else begin
				want = due_results.pop_front();
				if (status !== want.st)
					report_mismatch("status", 64'(status), 64'(want.st));
				if (out_time !== want.at)
					report_mismatch("out_time", out_time, want.at);
				if (out_kind !== want.kind)
					report_mismatch("out_kind", 64'(out_kind), 64'(want.kind));
				if (out_handle !== want.handle)
					report_mismatch("out_handle", 64'(out_handle), 64'(want.handle));
				if (now_time !== want.now)
					report_mismatch("now_time", now_time, want.now);
				if (pending !== want.pend)
					report_mismatch("pending", 64'(pending), 64'(want.pend));
				if (inserted_total !== want.total)
					report_mismatch("inserted_total", 64'(inserted_total), 64'(want.total));
				if (last !== want.fin)
					report_mismatch("last", 64'(last), 64'(want.fin));
			end
		end
	end

	task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == STOP_ADDR)
			stop_at = data;
	endtask

	task automatic confirm_stop_time();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= STOP_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== stop_at)
			report_mismatch("stop_time readback", prdata, stop_at);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic offer(input queue_op_t o);
		queued_ops.push_back(o);
		ops_queued++;
	endtask

	task automatic offer_insert(input logic [TIME_W-1:0] t, input logic [KIND_W-1:0] k,
			input logic [HANDLE_W-1:0] h);
		queue_op_t o;
		o.op = OP_INSERT;
		o.ev_time = t;
		o.ev_kind = k;
		o.ev_handle = h;
		o.goal = {$urandom, $urandom};
		offer(o);
	endtask

	task automatic offer_advance(input logic [TIME_W-1:0] goal);
		queue_op_t o;
		o.op = OP_ADVANCE;
		o.ev_time = {$urandom, $urandom};
		o.ev_kind = KIND_W'($urandom);
		o.ev_handle = $urandom;
		o.goal = goal;
		offer(o);
	endtask

	task automatic settle();
		while (ops_taken != ops_queued || due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [TIME_W-1:0] pick_time();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55)
			return TIME_W'($urandom_range(255));
		if (r < 62)
			return '0;
		if (r < 72)
			return T_MAX - TIME_W'($urandom_range(3));
		return {$urandom, $urandom};
	endfunction

	function automatic logic [KIND_W-1:0] pick_kind();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 12)
			return '0;
		if (r < 17)
			return '1;
		return KIND_W'($urandom);
	endfunction

	function automatic queue_op_t random_op(input int unsigned insert_pct);
		queue_op_t o;
		o.op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_ADVANCE;
		o.ev_time = pick_time();
		o.ev_kind = pick_kind();
		o.ev_handle = $urandom;
		o.goal = pick_time();
		return o;
	endfunction

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		confirm_stop_time();

		// Stop event armed at the all-ones time; equal-time order and a kind-zero event.
		offer_advance('0);
		offer_insert('0, 16'd5, '0);
		offer_insert(T_MAX, '1, '1);
		offer_insert(64'd100, 16'd1, 32'hA0A0_0001);
		offer_insert(64'd100, 16'd2, 32'hA0A0_0002);
		offer_insert(64'd100, '0, 32'hA0A0_0003);
		offer_insert(64'd100, 16'd3, 32'hA0A0_0004);
		offer_insert(64'd50, 16'h8000, 32'h1234_5678);
		offer_advance(64'd49);
		offer_advance(64'd100);
		offer_advance(64'd99);
		offer_advance(T_MAX - 1);
		offer_insert('0, 16'd9, 32'h5555_AAAA);
		offer_insert(64'h8000_0000_0000_0000, 16'h7FFF, 32'hAAAA_5555);
		settle();

		// A stop time of zero sits ahead of the stored event at time zero.
		reg_write(STOP_ADDR, '0);
		confirm_stop_time();
		reg_write(SPARE_ADDR, {$urandom, $urandom});
		confirm_stop_time();
		offer_advance('0);
		offer_advance('0);
		offer_advance(T_MAX);
		offer_advance(64'd5);
		settle();

		reg_write(STOP_ADDR, {$urandom, $urandom});
		confirm_stop_time();
		repeat (70) offer(random_op(55));
		settle();

		// Output held off while inserts queue up; the inserts then fill the store, so it rejects.
		reg_write(STOP_ADDR, T_MAX);
		confirm_stop_time();
		squeeze_req = 1'b1;
		repeat (40) offer(random_op(100));
		repeat (6) offer(random_op(30));
		settle();

		calm = 1'b1;
		repeat (80) offer(random_op(50));
		settle();
		calm = 1'b0;

		reg_write(STOP_ADDR, 64'd128);
		confirm_stop_time();
		repeat (64) offer(random_op(35));
		settle();

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/tepq_pkg.sv
hw/rtl/tepq_ram.sv
hw/rtl/timed_event_priority_queue.sv
test/tb_timed_event_priority_queue.sv
